/* rtl/core/skt_pkg.sv */
// ----------------------------------------------------------------------------
// skt_pkg: shared definitions for the k-th largest tracker
// Widths, reset values, sequencer states and the control/result bundles
// passed between the top level and the heap sequencer.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam int DATA_W    = 32;
    localparam int RANK_W    = 7;
    localparam int MAX_K_DEF = 64;

    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CMP,
        S_DN_LEFT,
        S_DN_RIGHT,
        S_PLACE,
        S_DONE
    } seq_state_t;

    typedef struct packed {
        logic start;
        logic clear;
        logic slot_free;
    } seq_ctl_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] kth_value;
        logic              have_k;
    } seq_res_t;

endpackage

/* rtl/core/skt_ram.sv */
// ----------------------------------------------------------------------------
// skt_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module skt_ram #(
    parameter int WIDTH = skt_pkg::DATA_W,
    parameter int DEPTH = skt_pkg::MAX_K_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/skt_seq.sv */
// ----------------------------------------------------------------------------
// skt_seq: min-heap sequencer
// Inserts with sift-up, replaces the root with sift-down or drops the sample,
// one heap level per pass, through the heap RAM and one shared signed comparator.
// ----------------------------------------------------------------------------
module skt_seq #(
    parameter int MAX_K = skt_pkg::MAX_K_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  skt_pkg::seq_ctl_t           ctl,
    input  logic [skt_pkg::RANK_W-1:0]  rank,
    input  logic [skt_pkg::DATA_W-1:0]  sample,
    output logic                        idle,
    output skt_pkg::seq_res_t           res
);

    localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW = $clog2(MAX_K + 1);
    localparam int EW = (CW > skt_pkg::RANK_W) ? CW : skt_pkg::RANK_W;
    localparam int LW = AW + 2;
    localparam int DW = skt_pkg::DATA_W;

    skt_pkg::seq_state_t state_reg, state_next;

    logic [AW-1:0] pos_reg, pos_next;
    logic [DW-1:0] val_reg, val_next;
    logic [CW-1:0] held_reg, held_next;
    logic [DW-1:0] best_val_reg, best_val_next;
    logic [AW-1:0] best_pos_reg, best_pos_next;
    logic          best_move_reg, best_move_next;
    logic [DW-1:0] root_reg, root_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [DW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic [DW-1:0] ram_rdata;

    logic [EW-1:0] rank_ext;
    logic [EW-1:0] k_wide;
    logic [CW-1:0] k_eff;

    logic [DW-1:0] cmp_a;
    logic [DW-1:0] cmp_b;
    logic          lt;

    logic          insert;
    logic [AW-1:0] held_pos;
    logic [AW-1:0] held_dec;
    logic [AW-1:0] held_par;
    logic [AW-1:0] pos_dec;
    logic [AW-1:0] par;
    logic [AW-1:0] par_dec;
    logic [AW-1:0] par_par;
    logic [LW-1:0] n_ext;
    logic [LW-1:0] left_idx;
    logic [LW-1:0] right_idx;
    logic          right_in;
    logic          root_left_in;
    logic [DW-1:0] cand_val;
    logic [AW-1:0] cand_pos;
    logic          cand_move;
    logic [LW-1:0] cand_left;
    logic          cand_left_in;

    skt_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_K),
        .AW    (AW)
    ) u_heap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // effective rank: zero acts as one, clamp to capacity
    always_comb
    begin
        rank_ext = EW'(rank);
        if (rank_ext == '0)
        begin
            k_wide = EW'(1);
        end
        else if (rank_ext > EW'(MAX_K))
        begin
            k_wide = EW'(MAX_K);
        end
        else
        begin
            k_wide = rank_ext;
        end
        k_eff = k_wide[CW-1:0];
    end

    // shared comparator
    always_comb
    begin
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                cmp_a = root_reg;
                cmp_b = sample;
            end
            skt_pkg::S_UP_CMP:
            begin
                cmp_a = val_reg;
                cmp_b = ram_rdata;
            end
            skt_pkg::S_DN_LEFT:
            begin
                cmp_a = ram_rdata;
                cmp_b = val_reg;
            end
            skt_pkg::S_DN_RIGHT:
            begin
                cmp_a = ram_rdata;
                cmp_b = best_val_reg;
            end
            default:
            begin
                cmp_a = val_reg;
                cmp_b = val_reg;
            end
        endcase
        lt = $signed(cmp_a) < $signed(cmp_b);
    end

    // index arithmetic and sift decisions
    always_comb
    begin
        insert       = held_reg < k_eff;
        held_pos     = held_reg[AW-1:0];
        held_dec     = held_pos - AW'(1);
        held_par     = held_dec >> 1;
        pos_dec      = pos_reg - AW'(1);
        par          = pos_dec >> 1;
        par_dec      = par - AW'(1);
        par_par      = par_dec >> 1;
        n_ext        = LW'(held_reg);
        left_idx     = LW'({pos_reg, 1'b1});
        right_idx    = left_idx + LW'(1);
        right_in     = right_idx < n_ext;
        root_left_in = n_ext > LW'(1);

        if (state_reg == skt_pkg::S_DN_RIGHT)
        begin
            if (lt)
            begin
                cand_val  = ram_rdata;
                cand_pos  = right_idx[AW-1:0];
                cand_move = 1'b1;
            end
            else
            begin
                cand_val  = best_val_reg;
                cand_pos  = best_pos_reg;
                cand_move = best_move_reg;
            end
        end
        else
        begin
            cand_val  = lt ? ram_rdata : val_reg;
            cand_pos  = lt ? left_idx[AW-1:0] : pos_reg;
            cand_move = lt;
        end
        cand_left    = LW'({cand_pos, 1'b1});
        cand_left_in = cand_left < n_ext;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    if (insert)
                    begin
                        state_next = (held_reg == '0) ? skt_pkg::S_DONE : skt_pkg::S_UP_CMP;
                    end
                    else if (lt && root_left_in)
                    begin
                        state_next = skt_pkg::S_DN_LEFT;
                    end
                    else
                    begin
                        state_next = skt_pkg::S_DONE;
                    end
                end
            end
            skt_pkg::S_UP_CMP:
            begin
                if (!lt)
                begin
                    state_next = skt_pkg::S_DONE;
                end
                else if (par == '0)
                begin
                    state_next = skt_pkg::S_PLACE;
                end
            end
            skt_pkg::S_DN_LEFT, skt_pkg::S_DN_RIGHT:
            begin
                if (state_reg == skt_pkg::S_DN_LEFT && right_in)
                begin
                    state_next = skt_pkg::S_DN_RIGHT;
                end
                else if (!cand_move)
                begin
                    state_next = skt_pkg::S_DONE;
                end
                else if (cand_left_in)
                begin
                    state_next = skt_pkg::S_DN_LEFT;
                end
                else
                begin
                    state_next = skt_pkg::S_PLACE;
                end
            end
            skt_pkg::S_PLACE:
            begin
                state_next = skt_pkg::S_DONE;
            end
            skt_pkg::S_DONE:
            begin
                if (ctl.slot_free)
                begin
                    state_next = skt_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = skt_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        pos_next       = pos_reg;
        val_next       = val_reg;
        held_next      = held_reg;
        best_val_next  = best_val_reg;
        best_pos_next  = best_pos_reg;
        best_move_next = best_move_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg;
        ram_wdata      = val_reg;
        ram_raddr      = '0;

        case (state_reg)
            skt_pkg::S_IDLE:
            begin
                if (ctl.start)
                begin
                    val_next = sample;
                    if (insert)
                    begin
                        held_next = held_reg + CW'(1);
                        pos_next  = held_pos;
                        if (held_reg == '0)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = sample;
                        end
                        else
                        begin
                            ram_raddr = held_par;
                        end
                    end
                    else if (lt)
                    begin
                        pos_next = '0;
                        if (root_left_in)
                        begin
                            ram_raddr = AW'(1);
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = '0;
                            ram_wdata = sample;
                        end
                    end
                end
            end
            skt_pkg::S_UP_CMP:
            begin
                ram_we = 1'b1;
                if (lt)
                begin
                    ram_wdata = ram_rdata;
                    pos_next  = par;
                    ram_raddr = par_par;
                end
            end
            skt_pkg::S_DN_LEFT, skt_pkg::S_DN_RIGHT:
            begin
                if (state_reg == skt_pkg::S_DN_LEFT && right_in)
                begin
                    best_val_next  = cand_val;
                    best_pos_next  = cand_pos;
                    best_move_next = cand_move;
                    ram_raddr      = right_idx[AW-1:0];
                end
                else
                begin
                    ram_we = 1'b1;
                    if (cand_move)
                    begin
                        ram_wdata = cand_val;
                        pos_next  = cand_pos;
                        ram_raddr = cand_left[AW-1:0];
                    end
                end
            end
            skt_pkg::S_PLACE:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (ctl.clear)
        begin
            held_next = '0;
        end

        root_next = (ram_we && ram_waddr == '0) ? ram_wdata : root_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= skt_pkg::S_IDLE;
            held_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            held_reg  <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        best_val_reg  <= best_val_next;
        best_pos_reg  <= best_pos_next;
        best_move_reg <= best_move_next;
        root_reg      <= root_next;
    end

    assign idle          = state_reg == skt_pkg::S_IDLE;
    assign res.done      = state_reg == skt_pkg::S_DONE;
    assign res.kth_value = root_reg;
    assign res.have_k    = held_reg >= k_eff;

endmodule

/* rtl/core/stream_kth_largest_tracker.sv */
// ----------------------------------------------------------------------------
// stream_kth_largest_tracker: k-th largest value of a signed stream
// Keeps a min-heap of at most k values and reports its root for every sample.
//
//   channel   direction  handshake                    payload
//   cfg       in         cfg_valid / cfg_ready        rank_k
//   sample    in         sample_valid / sample_ready  sample_value
//   result    out        result_valid / result_ready  kth_value, have_k
//
// A sample that is dropped, lands in an empty heap or replaces the only entry
// goes straight to done; an insert makes one compare per level on the way up
// and a replace makes one read for each child per level on the way down, all
// through the heap RAM's read port.
// Reset empties the heap and sets rank_k to 1; a rank_k write empties the heap.
// The result register lets the next sample start while a result is pending;
// a finished sample then holds until that result is taken.
// ----------------------------------------------------------------------------
module stream_kth_largest_tracker #(
    parameter int MAX_K = skt_pkg::MAX_K_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [skt_pkg::RANK_W-1:0]  rank_k,
    input  logic                        sample_valid,
    output logic                        sample_ready,
    input  logic [skt_pkg::DATA_W-1:0]  sample_value,
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic [skt_pkg::DATA_W-1:0]  kth_value,
    output logic                        have_k
);

    logic [skt_pkg::RANK_W-1:0] rank_reg, rank_next;
    logic                       result_valid_reg, result_valid_next;
    logic [skt_pkg::DATA_W-1:0] kth_value_reg, kth_value_next;
    logic                       have_k_reg, have_k_next;

    skt_pkg::seq_ctl_t ctl;
    skt_pkg::seq_res_t res;
    logic              idle;
    logic              cfg_fire;
    logic              load;

    assign cfg_ready     = idle;
    assign sample_ready  = idle && !cfg_valid;
    assign cfg_fire      = cfg_valid && cfg_ready;
    assign ctl.start     = sample_valid && sample_ready;
    assign ctl.clear     = cfg_fire;
    assign ctl.slot_free = !result_valid_reg || result_ready;
    assign load          = res.done && ctl.slot_free;

    skt_seq #(
        .MAX_K (MAX_K)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctl),
        .rank   (rank_reg),
        .sample (sample_value),
        .idle   (idle),
        .res    (res)
    );

    always_comb
    begin
        rank_next         = cfg_fire ? rank_k : rank_reg;
        result_valid_next = result_valid_reg;
        kth_value_next    = kth_value_reg;
        have_k_next       = have_k_reg;
        if (load)
        begin
            result_valid_next = 1'b1;
            kth_value_next    = res.kth_value;
            have_k_next       = res.have_k;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg         <= skt_pkg::RANK_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            rank_reg         <= rank_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kth_value_reg <= kth_value_next;
        have_k_reg    <= have_k_next;
    end

    assign result_valid = result_valid_reg;
    assign kth_value    = kth_value_reg;
    assign have_k       = have_k_reg;

endmodule
